// ===== rtl/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Block texel decoder package
// Shared types, format codes and small arithmetic helpers for the decoder.
// ----------------------------------------------------------------------------
package bcd_pkg;

    // Values of the block format register.
    localparam logic [1:0] FMT_BC1 = 2'd0;
    localparam logic [1:0] FMT_BC2 = 2'd1;
    localparam logic [1:0] FMT_BC3 = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        t_rgb [3:0] entry;
        logic       four_color;
    } t_palette;

    // floor(v * 255 / 31) = 8v + floor(7v / 31); the second term is a count
    // of thresholds crossed.
    function automatic logic [7:0] bcd_expand5(input logic [4:0] v);
        logic [7:0] t;
        logic [2:0] q;
        t = 8'(v) * 8'd7;
        q = 3'd0;
        for (int k = 1; k <= 7; k++) begin
            if (t >= 8'(31 * k)) begin
                q = q + 3'd1;
            end
        end
        return {v, 3'b000} + 8'(q);
    endfunction

    // floor(v * 255 / 63) = 4v + floor(v / 21).
    function automatic logic [7:0] bcd_expand6(input logic [5:0] v);
        logic [1:0] q;
        if (v >= 6'd63) begin
            q = 2'd3;
        end else if (v >= 6'd42) begin
            q = 2'd2;
        end else if (v >= 6'd21) begin
            q = 2'd1;
        end else begin
            q = 2'd0;
        end
        return {v, 2'b00} + 8'(q);
    endfunction

    // Truncating division by 3 for values up to 765.
    function automatic logic [7:0] bcd_div3(input logic [9:0] x);
        logic [19:0] p;
        p = x * 20'd683;
        return p[18:11];
    endfunction

    // Truncating division by 5 for values up to 1275.
    function automatic logic [7:0] bcd_div5(input logic [10:0] x);
        logic [22:0] p;
        p = x * 23'd3277;
        return p[21:14];
    endfunction

    // Truncating division by 7 for values up to 1785.
    function automatic logic [7:0] bcd_div7(input logic [10:0] x);
        logic [22:0] p;
        p = x * 23'd2341;
        return p[21:14];
    endfunction

endpackage

// ===== rtl/bcd_color_pal.sv =====
// ----------------------------------------------------------------------------
// Color palette builder
// Expands the two RGB565 endpoints and derives the in-between entries: two in
// four-color mode, one plus a black entry in three-color mode.
module bcd_color_pal import bcd_pkg::*; (
    input  logic [15:0] i_c0,
    input  logic [15:0] i_c1,
    output t_palette    o_pal
);

    t_rgb p0;
    t_rgb p1;
    logic four;

    assign p0.red   = bcd_expand5(i_c0[15:11]);
    assign p0.green = bcd_expand6(i_c0[10:5]);
    assign p0.blue  = bcd_expand5(i_c0[4:0]);
    assign p1.red   = bcd_expand5(i_c1[15:11]);
    assign p1.green = bcd_expand6(i_c1[10:5]);
    assign p1.blue  = bcd_expand5(i_c1[4:0]);
    assign four     = i_c0 > i_c1;

    function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
        return bcd_div3({1'b0, a, 1'b0} + {2'b00, b});
    endfunction

    function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8:1];
    endfunction

    always_comb begin
        o_pal.four_color = four;
        o_pal.entry[0]   = p0;
        o_pal.entry[1]   = p1;
        if (four) begin
            o_pal.entry[2].red   = third(p0.red,   p1.red);
            o_pal.entry[2].green = third(p0.green, p1.green);
            o_pal.entry[2].blue  = third(p0.blue,  p1.blue);
            o_pal.entry[3].red   = third(p1.red,   p0.red);
            o_pal.entry[3].green = third(p1.green, p0.green);
            o_pal.entry[3].blue  = third(p1.blue,  p0.blue);
        end else begin
            o_pal.entry[2].red   = half(p0.red,   p1.red);
            o_pal.entry[2].green = half(p0.green, p1.green);
            o_pal.entry[2].blue  = half(p0.blue,  p1.blue);
            o_pal.entry[3]       = '0;
        end
    end

endmodule

// ===== rtl/bcd_alpha.sv =====
// ----------------------------------------------------------------------------
// Texel alpha decoder
// Produces one texel's alpha for the selected block format.
// ----------------------------------------------------------------------------
module bcd_alpha import bcd_pkg::*; (
    input  logic [1:0]  i_fmt,
    input  logic [63:0] i_alpha_block,
    input  logic [3:0]  i_texel,
    input  logic [7:0]  i_bc1_alpha,
    output logic [7:0]  o_alpha
);

    logic [3:0]  nib;
    logic [5:0]  idx_pos;
    logic [2:0]  idx;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic        eight;
    logic [2:0]  w;
    logic [2:0]  wa;
    logic [10:0] sum;
    logic [7:0]  bc3;

    assign nib     = i_alpha_block[{i_texel, 2'b00} +: 4];
    assign idx_pos = 6'd16 + {2'b00, i_texel} + {1'b0, i_texel, 1'b0};
    assign idx     = i_alpha_block[idx_pos +: 3];
    assign a0      = i_alpha_block[7:0];
    assign a1      = i_alpha_block[15:8];
    assign eight   = a0 > a1;
    assign w       = idx - 3'd1;
    assign wa      = (eight ? 3'd7 : 3'd5) - w;
    assign sum     = 11'(wa) * 11'(a0) + 11'(w) * 11'(a1);

    always_comb begin
        if (idx == 3'd0) begin
            bc3 = a0;
        end else if (idx == 3'd1) begin
            bc3 = a1;
        end else if (eight) begin
            bc3 = bcd_div7(sum);
        end else if (idx == 3'd6) begin
            bc3 = 8'd0;
        end else if (idx == 3'd7) begin
            bc3 = 8'd255;
        end else begin
            bc3 = bcd_div5(sum);
        end
    end

    always_comb begin
        case (i_fmt)
            FMT_BC2: o_alpha = {nib, nib};
            FMT_BC3: o_alpha = bc3;
            default: o_alpha = i_bc1_alpha;
        endcase
    end

endmodule

// ===== rtl/bc_block_texel_decoder.sv =====
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 block texel decoder
// Turns one compressed 4x4 block into its sixteen RGBA8 texels.
// ----------------------------------------------------------------------------
// The input channel carries one compressed block per beat: the 64-bit color
// half and the 64-bit alpha half. The output channel carries one texel per
// beat in row-major order, tagged with its position in the block and with a
// flag on the sixteenth texel. A separate write channel sets the block format
// (BC1, BC2 or BC3); it is always ready and should only be written while the
// decoder is idle. Code 3 decodes as BC1.
//
// An accepted block sits in a block register. Whenever the output register is
// empty or being drained, the palette and the alpha of the current texel are
// formed from the block register and captured in the output register. The
// output register emits one texel per cycle while the receiver is ready; the
// next block is accepted in the cycle its predecessor's last texel moves to
// the output, with no bubble between blocks.
//
// When the receiver stalls, the output register holds its texel and the
// texel counter stops; the block register then stays full and the input
// side sees ready low. Reset empties both registers and selects BC1.
module bc_block_texel_decoder import bcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_color_block,
    input  logic [63:0] i_alpha_block,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [3:0]  o_texel_index,
    output logic        o_last_texel
);

    // Configuration and control state.
    logic [1:0]  r_fmt;
    logic        r_blk_vld;
    logic [3:0]  r_tex;
    logic        r_out_vld;

    // Block payload.
    logic [63:0] r_color;
    logic [63:0] r_alpha;

    // Output payload.
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic [7:0]  r_alpha_out;
    logic [3:0]  r_index;
    logic        r_last;

    logic        advance;
    logic        tex_last;
    logic        in_fire;
    t_palette    pal;
    logic [1:0]  ci;
    t_rgb        color;
    logic [7:0]  bc1_alpha;
    logic [7:0]  n_alpha;

    assign o_cfg_ready = 1'b1;

    // A texel moves forward whenever a block is loaded and the output
    // register is empty or being drained this cycle.
    assign advance    = r_blk_vld && (!r_out_vld || i_out_ready);
    assign tex_last   = r_tex == 4'd15;
    assign o_in_ready = !r_blk_vld || (advance && tex_last);
    assign in_fire    = i_in_valid && o_in_ready;

    bcd_color_pal u_pal (
        .i_c0  (r_color[15:0]),
        .i_c1  (r_color[31:16]),
        .o_pal (pal)
    );

    // Two-bit color index of the current texel sits at bit 32 + 2 * texel.
    assign ci = r_color[{1'b1, r_tex, 1'b0} +: 2];

    always_comb begin
        case (ci)
            2'd0:    color = pal.entry[0];
            2'd1:    color = pal.entry[1];
            2'd2:    color = pal.entry[2];
            default: color = pal.entry[3];
        endcase
    end

    // In three-color mode the last entry is transparent black.
    assign bc1_alpha = (ci == 2'd3 && !pal.four_color) ? 8'd0 : 8'd255;

    bcd_alpha u_alpha (
        .i_fmt         (r_fmt),
        .i_alpha_block (r_alpha),
        .i_texel       (r_tex),
        .i_bc1_alpha   (bc1_alpha),
        .o_alpha       (n_alpha)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= FMT_BC1;
            r_blk_vld <= 1'b0;
            r_tex     <= 4'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_fmt <= i_cfg_data;
            end
            if (in_fire) begin
                r_blk_vld <= 1'b1;
            end else if (advance && tex_last) begin
                r_blk_vld <= 1'b0;
            end
            if (in_fire) begin
                r_tex <= 4'd0;
            end else if (advance) begin
                r_tex <= r_tex + 4'd1;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_color <= i_color_block;
            r_alpha <= i_alpha_block;
        end
        if (advance) begin
            r_red       <= color.red;
            r_green     <= color.green;
            r_blue      <= color.blue;
            r_alpha_out <= n_alpha;
            r_index     <= r_tex;
            r_last      <= tex_last;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_alpha       = r_alpha_out;
    assign o_texel_index = r_index;
    assign o_last_texel  = r_last;

endmodule

// ===== bench/bc_block_texel_decoder_test.sv =====
// ----------------------------------------------------------------------------
// BC block texel decoder testbench
// Feeds compressed 4x4 blocks under every block format and checks each
// decoded texel against a behavioral decoder kept inside the bench.
// ----------------------------------------------------------------------------
module bc_block_texel_decoder_test;
    import bcd_pkg::*;

    // The register is two bits wide; code 3 has no format of its own and
    // must decode exactly like BC1.
    localparam logic [1:0] FMT_SPARE = 2'd3;

    // The run is aborted well beyond the slowest legal run: about 400 blocks
    // under the sparsest receiver, plus sender gaps, the long receiver hold-off
    // and the drains between phases.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int END_WAIT      = 20000;
    localparam int DRAIN_PAD     = 3;
    localparam int PRINT_LIMIT   = 50;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [3:0] texel_index;
        logic       last_texel;
    } t_texel;

    // Receiver behaviors; one is picked for each stretch of cycles.
    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data    = FMT_BC1;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [63:0] i_color_block = '0;
    logic [63:0] i_alpha_block = '0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic [3:0]  o_texel_index;
    logic        o_last_texel;

    // Texels the decoder still owes us, oldest first.
    t_texel      expected_texels [$];
    // Format the decoder is running with, tracked from the config beats.
    logic [1:0]  format_shadow = FMT_BC1;

    int          error_count    = 0;
    int          texels_checked = 0;
    int          blocks_sent    = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;
    int          hold_request   = 0;
    int          hold_left      = 0;
    int          mode_left      = 0;
    t_rx_mode    rx_mode        = RX_STEADY;

    bc_block_texel_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_color_block (i_color_block),
        .i_alpha_block (i_alpha_block),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_texel_index (o_texel_index),
        .o_last_texel  (o_last_texel)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioral decoder
    // ------------------------------------------------------------------------

    // RGB565 channel widening with truncation: v * 255 / 31 and v * 255 / 63.
    function automatic int widen5(input logic [4:0] v);
        return (int'(v) * 255) / 31;
    endfunction

    function automatic int widen6(input logic [5:0] v);
        return (int'(v) * 255) / 63;
    endfunction

    // BC3 alpha: codes 0 and 1 are the endpoints. With a0 > a1 the other six
    // codes are evenly spaced sevenths; otherwise codes 2..5 are fifths and
    // codes 6 and 7 are fully transparent and fully opaque.
    function automatic logic [7:0] ramp_alpha(input int a0, input int a1,
                                              input logic [2:0] code);
        int c;
        c = int'(code);
        if (c == 0) begin
            return 8'(a0);
        end
        if (c == 1) begin
            return 8'(a1);
        end
        if (a0 > a1) begin
            return 8'(((8 - c) * a0 + (c - 1) * a1) / 7);
        end
        if (c == 6) begin
            return 8'd0;
        end
        if (c == 7) begin
            return 8'd255;
        end
        return 8'(((6 - c) * a0 + (c - 1) * a1) / 5);
    endfunction

    // Decodes one block under the given format and appends its sixteen
    // texels to the expectation queue in row-major order.
    task automatic queue_block_texels(input logic [63:0] cb, input logic [63:0] ab,
                                      input logic [1:0] fmt);
        int     c0;
        int     c1;
        int     a0;
        int     a1;
        int     pick;
        int     pal [4][3];
        t_texel tx;
        c0 = int'(cb[15:0]);
        c1 = int'(cb[31:16]);
        a0 = int'(ab[7:0]);
        a1 = int'(ab[15:8]);
        pal[0][0] = widen5(cb[15:11]);
        pal[0][1] = widen6(cb[10:5]);
        pal[0][2] = widen5(cb[4:0]);
        pal[1][0] = widen5(cb[31:27]);
        pal[1][1] = widen6(cb[26:21]);
        pal[1][2] = widen5(cb[20:16]);
        for (int ch = 0; ch < 3; ch++) begin
            if (c0 > c1) begin
                pal[2][ch] = (2 * pal[0][ch] + pal[1][ch]) / 3;
                pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch]) / 3;
            end else begin
                pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
                pal[3][ch] = 0;
            end
        end
        for (int t = 0; t < 16; t++) begin
            pick = int'(cb[32 + 2 * t +: 2]);
            tx.red   = 8'(pal[pick][0]);
            tx.green = 8'(pal[pick][1]);
            tx.blue  = 8'(pal[pick][2]);
            case (fmt)
                FMT_BC2: begin
                    tx.alpha = 8'(int'(ab[4 * t +: 4]) * 17);
                end
                FMT_BC3: begin
                    tx.alpha = ramp_alpha(a0, a1, ab[16 + 3 * t +: 3]);
                end
                default: begin
                    // BC1 and the spare code: only the black entry of the
                    // three-color mode is transparent.
                    tx.alpha = (c0 <= c1 && pick == 3) ? 8'd0 : 8'd255;
                end
            endcase
            tx.texel_index = 4'(t);
            tx.last_texel  = (t == 15);
            expected_texels = {expected_texels, tx};
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("block %0d texel %0d %s: got %0h, expected %0h",
                                      texels_checked / 16, texels_checked % 16,
                                      name, got, want));
        end
    endtask

    // Everything is sampled at the rising edge, before the decoder's own
    // registers update, so the values seen are the ones the decoder saw.
    // Output beats are retired before new blocks are predicted; a block
    // accepted at this edge cannot produce a texel before the next one.
    always @(posedge i_clk) begin
        t_texel want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_texels.size() == 0) begin
                    report_mismatch($sformatf("texel beat with nothing expected (index %0d)",
                                              o_texel_index));
                end else begin
                    want = expected_texels.pop_front();
                    check_field("red",         o_red,         want.red);
                    check_field("green",       o_green,       want.green);
                    check_field("blue",        o_blue,        want.blue);
                    check_field("alpha",       o_alpha,       want.alpha);
                    check_field("texel_index", 8'(o_texel_index), 8'(want.texel_index));
                    check_field("last_texel",  8'(o_last_texel),  8'(want.last_texel));
                    texels_checked++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                format_shadow <= i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                queue_block_texels(i_color_block, i_alpha_block, format_shadow);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------------

    // The receiver switches between behaviors for stretches of random length:
    // always ready, coin toss, ready at random about one time in four, and
    // alternating. A hold-off request from the test sequence forces ready low
    // for that many cycles, counted here.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            case (rx_mode)
                RX_STEADY: i_out_ready <= 1'b1;
                RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                default:   i_out_ready <= ~i_out_ready;
            endcase
        end
    end

    // Backstop against a hung decoder.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d texels outstanding",
                     cycle_count, expected_texels.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offers one block and returns at the edge where it is accepted. Valid
    // is left high on return; the next beat either reuses it directly or
    // lowers it for a gap, so valid never drops and rises in the same step.
    // Blocks go out in bursts of random length separated by random gaps,
    // mostly short and now and then long.
    task automatic send_block(input logic [63:0] cb, input logic [63:0] ab);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(0, 5);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_color_block <= cb;
        i_alpha_block <= ab;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        blocks_sent++;
    endtask

    // Random block with a bias toward the interesting endpoint relations: equal
    // colors, forced four-color order, equal alpha endpoints and six-entry alpha order.
    task automatic send_random_block();
        logic [63:0] cb;
        logic [63:0] ab;
        cb = {$urandom, $urandom};
        ab = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: cb[31:16] = cb[15:0];
            1: begin
                if (cb[15:0] < cb[31:16]) begin
                    cb[31:0] = {cb[15:0], cb[31:16]};
                end
            end
            2: ab[15:8] = ab[7:0];
            3: begin
                if (ab[7:0] > ab[15:8]) begin
                    ab[15:0] = {ab[7:0], ab[15:8]};
                end
            end
            default: ;
        endcase
        send_block(cb, ab);
    endtask

    // Stops offering and waits until every expected texel has come back.
    // Every block yields texels, so an empty queue means the decoder is idle;
    // the pad only covers the last beat settling.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_texels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_format(input logic [1:0] fmt);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= fmt;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // BC1 palette modes. The index word E4E4E4E4 walks every texel row
    // through entries 0, 1, 2, 3, so each mode shows all four entries.
    task automatic test_bc1_endpoints();
        write_format(FMT_BC1);
        send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, {$urandom, $urandom});
        send_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, {$urandom, $urandom});
        send_block({32'hE4E4_E4E4, 16'h1234, 16'h1234}, {$urandom, $urandom});
        send_block(64'h0, 64'h0);
        send_block({64{1'b1}}, {64{1'b1}});
        // Endpoints one apart on either side of the mode switch.
        send_block({32'h1B1B_1B1B, 16'h7BEF, 16'h7BF0}, {$urandom, $urandom});
        send_block({32'h1B1B_1B1B, 16'h7BF0, 16'h7BEF}, {$urandom, $urandom});
        send_block({$urandom, 16'h07E0, 16'hF800}, {$urandom, $urandom});
    endtask

    // BC2 nibble alpha, including the black entry taking its alpha from the
    // alpha half instead of going transparent.
    task automatic test_bc2_explicit_alpha();
        write_format(FMT_BC2);
        send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, 64'hFEDC_BA98_7654_3210);
        send_block({32'hFFFF_FFFF, 16'hFFFF, 16'h0000}, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block({32'hE4E4_E4E4, 16'h8410, 16'h8410}, 64'h0);
        send_block({$urandom, $urandom}, 64'h0123_4567_89AB_CDEF);
    endtask

    // BC3 alpha ramps: eight-entry and six-entry tables, endpoints at the
    // extremes, equal endpoints, and the black color entry with ramp alpha.
    task automatic test_bc3_alpha_ramp();
        logic [47:0] ramp;
        logic [47:0] ramp_down;
        for (int i = 0; i < 16; i++) begin
            ramp[3 * i +: 3]      = 3'(i % 8);
            ramp_down[3 * i +: 3] = 3'(7 - i % 8);
        end
        write_format(FMT_BC3);
        send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, {ramp, 8'd0, 8'd255});
        send_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, {ramp, 8'd255, 8'd0});
        send_block({$urandom, $urandom}, {ramp, 8'd128, 8'd128});
        send_block({$urandom, $urandom}, {ramp_down, 8'd37, 8'd200});
        send_block({$urandom, $urandom}, {ramp_down, 8'd250, 8'd5});
        send_block({64{1'b1}}, {64{1'b1}});
    endtask

    // The spare format code must ignore the alpha half entirely.
    task automatic test_spare_format();
        write_format(FMT_SPARE);
        send_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, {64{1'b1}});
        send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, 64'hFEDC_BA98_7654_3210);
    endtask

    task automatic test_random_blocks(input logic [1:0] fmt, input int count);
        write_format(fmt);
        repeat (count) send_random_block();
    endtask

    // The receiver holds off for a long stretch while blocks keep coming, so
    // the decoder fills and must stall its input. Afterwards the sender
    // pauses until the decoder has delivered everything.
    task automatic test_backpressure();
        write_format(FMT_BC2);
        hold_request = HOLD_CYCLES;
        repeat (15) send_random_block();
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        int waited;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bc1_endpoints();
        test_bc2_explicit_alpha();
        test_bc3_alpha_ramp();
        test_spare_format();
        test_random_blocks(FMT_BC1, 90);
        test_random_blocks(FMT_BC2, 90);
        test_random_blocks(FMT_BC3, 110);
        test_random_blocks(FMT_SPARE, 30);
        test_backpressure();
        test_random_blocks(FMT_BC1, 20);

        // Drain with a bound of its own so leftovers are reported as such.
        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_texels.size() != 0 && waited < END_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_PAD + 5) @(posedge i_clk);
        if (expected_texels.size() != 0) begin
            report_mismatch($sformatf("%0d expected texels never arrived",
                                      expected_texels.size()));
        end

        $display("Decoded %0d blocks, %0d texels compared, %0d mismatches.",
                 blocks_sent, texels_checked, error_count);
        $display("Formats BC1, BC2, BC3 and the spare code; idle gaps, stalls, long hold-off.");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
